/* src/float_matrix_multiply_core_defines.svh */
// Assertion macros for the matrix multiply core checker
`ifndef FLOAT_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define FLOAT_MATRIX_MULTIPLY_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define FMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication checked outside reset
`define FMM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

/* src/fmm_pkg.sv */
// Shared constants, types and binary32 helpers for the matrix multiply core
`default_nettype none
package fmm_pkg;
   localparam int MaxRows  = 8;
   localparam int MaxInner = 8;
   localparam int MaxCols  = 8;
   localparam int RowW = $clog2(MaxRows);
   localparam int InnW = $clog2(MaxInner);
   localparam int ColW = $clog2(MaxCols);
   localparam logic [31:0] CanonNan = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_A_ROWS    = 2'd0,
      CSR_INNER_LEN = 2'd1,
      CSR_B_COLS    = 2'd2,
      CSR_NONE      = 2'd3
   } csr_index_type;

   // FPU operation request
   typedef struct packed {
      logic        start;
      logic        is_add;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   // Clamp a 4-bit dimension into 1..mx
   function automatic logic [3:0] clamp_dim(input logic [3:0] v, input logic [3:0] mx);
      logic [3:0] r;
      begin
         r = v;
         if (v == 4'd0) r = 4'd1;
         if (v > mx) r = mx;
         return r;
      end
   endfunction
endpackage
`default_nettype wire

/* src/fmm_fpu.sv */
// Shared multi-cycle binary32 multiply/add unit with round-to-nearest-even
`default_nettype none
module fmm_fpu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fmm_pkg::fpu_req_type req,
   output fmm_pkg::fpu_rsp_type      rsp
);
   import fmm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ALIGN = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_NORM  = 6'b010000,
      ST_ROUND = 6'b100000
   } fpu_state_type;

   fpu_state_type state_ff, state_in;
   logic        is_add_ff, is_add_in;
   logic        sa_ff, sa_in, sb_ff, sb_in;
   logic [9:0]  ea_ff, ea_in, eb_ff, eb_in;      // biased exponents
   logic [23:0] ma_ff, ma_in, mb_ff, mb_in;
   logic        spec_ff, spec_in;                // special-case result ready
   logic [31:0] spec_val_ff, spec_val_in;
   logic        rs_ff, rs_in;                    // result sign
   logic signed [10:0] re_ff, re_in;             // result exponent
   logic [49:0] rm_ff, rm_in;                    // result magnitude, point after bit 48
   logic [5:0]  nsh_ff, nsh_in;                  // leading zero count
   logic [31:0] res_ff, res_in;
   logic        done_ff, done_in;

   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [47:0] prod;
   logic [9:0]  ediff;
   logic [49:0] big, sml, sml_sh;
   logic        sticky;
   logic [50:0] sum_ext;
   logic [5:0]  lz;
   logic [49:0] nm;
   logic signed [10:0] ne;
   logic [49:0] dn;
   logic [24:0] mant_r;
   logic        g, st, lsb, rup;
   logic [8:0]  sh_dn;
   logic [31:0] packed_res;

   // Operand classification
   always_comb begin
      a_nan  = (req.op_a[30:23] == 8'hFF) && (req.op_a[22:0] != 23'd0);
      b_nan  = (req.op_b[30:23] == 8'hFF) && (req.op_b[22:0] != 23'd0);
      a_inf  = (req.op_a[30:23] == 8'hFF) && (req.op_a[22:0] == 23'd0);
      b_inf  = (req.op_b[30:23] == 8'hFF) && (req.op_b[22:0] == 23'd0);
      a_zero = (req.op_a[30:0] == 31'd0);
      b_zero = (req.op_b[30:0] == 31'd0);
   end

   assign prod  = ma_ff * mb_ff;
   assign ediff = ea_ff - eb_ff;

   // Sticky-preserving right shift of the smaller addend, then add or subtract
   always_comb begin
      big = {1'b0, ma_ff, 25'd0};
      sml = {1'b0, mb_ff, 25'd0};
      sticky = 1'b0;
      if (ediff > 10'd49) begin
         sml_sh = {49'd0, (mb_ff != 24'd0)};
      end else begin
         sml_sh = sml >> ediff[5:0];
         sticky = ((sml_sh << ediff[5:0]) != sml);
         sml_sh[0] = sml_sh[0] | sticky;
      end
      sum_ext = (sa_ff == sb_ff) ? ({1'b0, big} + {1'b0, sml_sh})
                                 : ({1'b0, big} - {1'b0, sml_sh});
   end

   // Leading zero count of the magnitude
   always_comb begin
      lz = 6'd50;
      for (int i = 0; i < 50; i++) begin
         if (rm_ff[i]) lz = 6'(49 - i);
      end
   end

   // Normalise to bit 49, denormalise, round and pack
   always_comb begin
      nm = rm_ff << nsh_ff;
      ne = re_ff - 11'(nsh_ff);
      dn = nm;
      sh_dn = 9'd0;
      if (ne < 11'sd1) begin
         sh_dn = 9'(11'sd1 - ne);
         if (sh_dn > 9'd50) dn = {49'd0, (nm != 50'd0)};
         else dn = (nm >> sh_dn[5:0]) | {49'd0, ((nm << (6'd50 - sh_dn[5:0])) != 50'd0)};
      end
      mant_r = {1'b0, dn[49:26]};
      g   = dn[25];
      st  = (dn[24:0] != 25'd0);
      lsb = dn[26];
      rup = g & (st | lsb);
      mant_r = mant_r + 25'(rup);
      if (ne < 11'sd1) begin
         packed_res = {rs_ff, 8'(mant_r[23]), mant_r[22:0]};
      end else if (mant_r[24]) begin
         if (ne + 11'sd1 >= 11'sd255) packed_res = {rs_ff, 8'hFF, 23'd0};
         else packed_res = {rs_ff, 8'(ne + 11'sd1), mant_r[23:1]};
      end else if (ne >= 11'sd255) begin
         packed_res = {rs_ff, 8'hFF, 23'd0};
      end else begin
         packed_res = {rs_ff, ne[7:0], mant_r[22:0]};
      end
   end

   // Sequence the operation
   always_comb begin
      state_in = state_ff;
      is_add_in = is_add_ff;
      sa_in = sa_ff; sb_in = sb_ff; ea_in = ea_ff; eb_in = eb_ff;
      ma_in = ma_ff; mb_in = mb_ff;
      spec_in = spec_ff; spec_val_in = spec_val_ff;
      rs_in = rs_ff; re_in = re_ff; rm_in = rm_ff; nsh_in = nsh_ff;
      res_in = res_ff;
      done_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               is_add_in = req.is_add;
               sa_in = req.op_a[31];
               sb_in = req.op_b[31];
               ea_in = (req.op_a[30:23] == 8'd0) ? 10'd1 : {2'b0, req.op_a[30:23]};
               eb_in = (req.op_b[30:23] == 8'd0) ? 10'd1 : {2'b0, req.op_b[30:23]};
               ma_in = {(req.op_a[30:23] != 8'd0), req.op_a[22:0]};
               mb_in = {(req.op_b[30:23] != 8'd0), req.op_b[22:0]};
               spec_in = 1'b1;
               if (a_nan || b_nan) begin
                  spec_val_in = CanonNan;
               end else if (!req.is_add) begin
                  if ((a_inf && b_zero) || (b_inf && a_zero)) spec_val_in = CanonNan;
                  else if (a_inf || b_inf)
                     spec_val_in = {req.op_a[31] ^ req.op_b[31], 8'hFF, 23'd0};
                  else spec_in = 1'b0;
               end else begin
                  if (a_inf && b_inf && (req.op_a[31] != req.op_b[31])) spec_val_in = CanonNan;
                  else if (a_inf) spec_val_in = req.op_a;
                  else if (b_inf) spec_val_in = req.op_b;
                  else if (a_zero && b_zero)
                     spec_val_in = {req.op_a[31] & req.op_b[31], 31'd0};
                  else spec_in = 1'b0;
               end
               // Order addends so the first has the larger magnitude
               if (req.is_add && (req.op_b[30:0] > req.op_a[30:0])) begin
                  sa_in = req.op_b[31]; sb_in = req.op_a[31];
                  ea_in = (req.op_b[30:23] == 8'd0) ? 10'd1 : {2'b0, req.op_b[30:23]};
                  eb_in = (req.op_a[30:23] == 8'd0) ? 10'd1 : {2'b0, req.op_a[30:23]};
                  ma_in = {(req.op_b[30:23] != 8'd0), req.op_b[22:0]};
                  mb_in = {(req.op_a[30:23] != 8'd0), req.op_a[22:0]};
               end
               state_in = req.is_add ? ST_ALIGN : ST_MUL;
            end
         end
         ST_MUL: begin
            rs_in = sa_ff ^ sb_ff;
            rm_in = {prod, 2'b00};
            re_in = 11'(signed'({1'b0, ea_ff})) + 11'(signed'({1'b0, eb_ff})) - 11'sd126;
            state_in = ST_NORM;
         end
         ST_ALIGN: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rs_in = sa_ff;
            rm_in = sum_ext[50] ? {sum_ext[50:2], sum_ext[1] | sum_ext[0]} : sum_ext[49:0];
            re_in = 11'(signed'({1'b0, ea_ff})) + (sum_ext[50] ? 11'sd2 : 11'sd1);
            // Exact cancellation gives +0, unless a special result is already set
            if (!spec_ff && (sum_ext == 51'd0)) begin
               spec_in = 1'b1;
               spec_val_in = 32'd0;
            end
            state_in = ST_NORM;
         end
         ST_NORM: begin
            nsh_in = lz;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (spec_ff) res_in = spec_val_ff;
            else if (rm_ff == 50'd0) res_in = {rs_ff, 31'd0};
            else res_in = packed_res;
            done_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      is_add_ff <= is_add_in;
      sa_ff <= sa_in; sb_ff <= sb_in; ea_ff <= ea_in; eb_ff <= eb_in;
      ma_ff <= ma_in; mb_ff <= mb_in;
      spec_ff <= spec_in; spec_val_ff <= spec_val_in;
      rs_ff <= rs_in; re_ff <= re_in; rm_ff <= rm_in; nsh_ff <= nsh_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;
endmodule
`default_nettype wire

/* src/float_matrix_multiply_core.sv */
// Top level of the binary32 dense matrix multiply core
// Writes of A and B go into two 64-entry memories. A compute transfer walks C
// in row-major order; for each term the sequencer fetches the operand pair
// (READ, LOAD), then issues the product and then the add on one shared
// multi-cycle FPU. A stalled result holds the sequencer in its emit step. The
// core holds req_ready low throughout a compute, until the final result has
// been taken.
`default_nettype none
module float_matrix_multiply_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [3:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [2:0]  req_row_index,
   input  wire logic [2:0]  req_col_index,
   input  wire logic [31:0] req_element_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_out_row,
   output logic [2:0]       rsp_out_col,
   output logic [31:0]      rsp_sum_bits,
   output logic             rsp_last_flag
);
   import fmm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_ADD   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_WAIT  = 7'b1000000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [3:0] a_rows_ff, inner_ff, b_cols_ff;
   logic [3:0] nr, nk, nc;
   logic [RowW-1:0] i_ff, i_in;
   logic [ColW-1:0] j_ff, j_in;
   logic [InnW-1:0] k_ff, k_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] a_mem [MaxRows*MaxInner];
   logic [31:0] b_mem [MaxInner*MaxCols];
   logic [31:0] a_rd_ff, b_rd_ff;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_row_ff, out_col_ff;
   logic [31:0] out_sum_ff;
   logic        out_last_ff;
   logic        issued_ff, issued_in;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;
   logic        req_fire, do_compute;
   logic        last_k, last_j, last_i;

   fmm_fpu u_fpu (.clock(clock), .reset(reset), .req(fpu_req), .rsp(fpu_rsp));

   assign nr = clamp_dim(a_rows_ff, 4'(MaxRows));
   assign nk = clamp_dim(inner_ff, 4'(MaxInner));
   assign nc = clamp_dim(b_cols_ff, 4'(MaxCols));
   assign last_k = ({1'b0, k_ff} == 4'(nk - 4'd1));
   assign last_j = ({1'b0, j_ff} == 4'(nc - 4'd1));
   assign last_i = ({1'b0, i_ff} == 4'(nr - 4'd1));

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign do_compute = req_fire && (req_opcode == OP_COMPUTE);

   // Hold the dimension registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= 4'd8;
         inner_ff  <= 4'd8;
         b_cols_ff <= 4'd8;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_A_ROWS:    a_rows_ff <= csr_write_data;
            CSR_INNER_LEN: inner_ff  <= csr_write_data;
            CSR_B_COLS:    b_cols_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Store elements and read operand pairs
   always_ff @(posedge clock) begin
      if (req_fire && (req_opcode == OP_WRITE_A)) a_mem[{req_row_index, req_col_index}] <= req_element_bits;
      if (req_fire && (req_opcode == OP_WRITE_B)) b_mem[{req_row_index, req_col_index}] <= req_element_bits;
      a_rd_ff <= a_mem[{i_ff, k_ff}];
      b_rd_ff <= b_mem[{k_ff, j_ff}];
   end

   // Drive the shared FPU
   always_comb begin
      fpu_req.start  = 1'b0;
      fpu_req.is_add = 1'b0;
      fpu_req.op_a   = a_rd_ff;
      fpu_req.op_b   = b_rd_ff;
      if (state_ff == ST_MUL && !issued_ff) fpu_req.start = 1'b1;
      if (state_ff == ST_ADD && !issued_ff) begin
         fpu_req.start  = 1'b1;
         fpu_req.is_add = 1'b1;
         fpu_req.op_a   = acc_ff;
         fpu_req.op_b   = fpu_rsp.result;
      end
   end

   // Sequence the dot products
   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      acc_in = acc_ff;
      issued_in = issued_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_compute) begin
               i_in = '0; j_in = '0; k_in = '0;
               acc_in = 32'd0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            issued_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               issued_in = 1'b0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               acc_in = fpu_rsp.result;
               if (last_k) state_in = ST_EMIT;
               else begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               acc_in = 32'd0;
               k_in = '0;
               if (last_j) begin
                  j_in = '0;
                  if (last_i) state_in = ST_WAIT;
                  else begin
                     i_in = i_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_WAIT: begin
            if (!out_valid_in) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         issued_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         issued_ff    <= issued_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      acc_ff <= acc_in;
      if (state_ff == ST_EMIT && (!out_valid_ff || rsp_ready)) begin
         out_row_ff  <= 3'(i_ff);
         out_col_ff  <= 3'(j_ff);
         out_sum_ff  <= acc_ff;
         out_last_ff <= last_i && last_j;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_sum_bits  = out_sum_ff;
   assign rsp_last_flag = out_last_ff;
endmodule
`default_nettype wire

/* src/fmm_checker.sv */
// Port-level checker for the matrix multiply core, bound to the top level
`default_nettype none
`include "float_matrix_multiply_core_defines.svh"
module fmm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_opcode,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_sum_bits,
   input wire logic        rsp_last_flag
);
   import fmm_pkg::*;
   // Hold a stalled result
   `FMM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum_bits))
   // No request taken while a result waits
   `FMM_ASSERT_IMP(a_busy, clock, reset, rsp_valid, !req_ready)
   // Compute drops ready next cycle
   `FMM_ASSERT_NXT(a_cmp_busy, clock, reset, req_valid && req_ready && (req_opcode == OP_COMPUTE), !req_ready)
   // Drop valid once the final element is transferred
   `FMM_ASSERT_NXT(a_last_end, clock, reset, rsp_valid && rsp_ready && rsp_last_flag, !rsp_valid)
endmodule
bind float_matrix_multiply_core fmm_checker u_fmm_checker (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the binary32 matrix multiply core
`timescale 1ns / 1ps
module tb_top;
   import fmm_pkg::*;

   localparam int StallLimit = 40000;
   localparam int SettleCycles = 200;

   typedef struct {
      opcode_type  op;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] bits;
   } mm_cmd_type;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] sum;
      logic        last;
   } c_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_A_ROWS;
   logic [3:0]  csr_write_data = 4'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_NONE;
   logic [2:0]  req_row_index = 3'd0;
   logic [2:0]  req_col_index = 3'd0;
   logic [31:0] req_element_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_out_row;
   logic [2:0]  rsp_out_col;
   logic [31:0] rsp_sum_bits;
   logic        rsp_last_flag;

   float_matrix_multiply_core dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .req_element_bits(req_element_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_sum_bits(rsp_sum_bits),
      .rsp_last_flag(rsp_last_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block state
   logic [31:0] a_mat [64];
   logic [31:0] b_mat [64];
   bit          a_filled [64];
   bit          b_filled [64];
   logic [3:0]  rows_reg = 4'd8;
   logic [3:0]  inner_reg = 4'd8;
   logic [3:0]  cols_reg = 4'd8;

   mm_cmd_type  cmd_q [$];
   c_elem_type  c_expect_q [$];
   int       errors = 0;
   bit       fast_mode = 1'b0;

   // Widen a binary32 pattern to a double exactly
   function automatic real f32_to_real(logic [31:0] b);
      logic [63:0] d;
      logic [63:0] t;
      int p;
      p = 0;
      if (b[30:23] == 8'hFF) begin
         d = (b[22:0] == 0) ? {b[31], 11'h7FF, 52'd0} : {b[31], 11'h7FF, 1'b1, 51'd0};
      end else if (b[30:23] == 8'd0) begin
         if (b[22:0] == 0) begin
            d = {b[31], 63'd0};
         end else begin
            for (int i = 0; i < 23; i++) if (b[i]) p = i;
            t = 64'(b[22:0]) << (52 - p);
            d = {b[31], 11'(p + 874), t[51:0]};
         end
      end else begin
         d = {b[31], 11'(int'(b[30:23]) + 896), b[22:0], 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // Round a double to binary32, nearest-even, NaN made canonical
   function automatic logic [31:0] real_to_f32(real x);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] r;
      logic [63:0] base;
      int ue;
      int u;
      int sh;
      d = $realtobits(x);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? CanonNan : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      ue = d[62:52];
      u = ue - 1023;
      if (u > 127) return {d[63], 8'hFF, 23'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      if (u >= -126) begin
         sh = 29;
         base = 64'(u + 126) << 23;
      end else begin
         sh = -97 - u;
         base = 64'd0;
      end
      if (sh > 60) return {d[63], 31'd0};
      kept = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      r = base + kept;
      if (rem > half || (rem == half && kept[0])) r = r + 64'd1;
      if (r >= 64'h7F80_0000) r = 64'h7F80_0000;
      return {d[63], r[30:0]};
   endfunction

   function automatic int eff_dim(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > 4'd8) return 8;
      return int'(v);
   endfunction

   // Apply one transferred command: update stores or predict every C element
   function automatic void apply_cmd(mm_cmd_type it);
      int nr;
      int nk;
      int nc;
      real acc;
      real prod;
      c_elem_type e;
      nr = eff_dim(rows_reg);
      nk = eff_dim(inner_reg);
      nc = eff_dim(cols_reg);
      case (it.op)
         OP_WRITE_A: a_mat[{it.row, it.col}] = it.bits;
         OP_WRITE_B: b_mat[{it.row, it.col}] = it.bits;
         OP_COMPUTE: begin
            for (int i = 0; i < nr; i++) begin
               for (int j = 0; j < nc; j++) begin
                  acc = 0.0;
                  for (int k = 0; k < nk; k++) begin
                     prod = f32_to_real(a_mat[i*8+k]) * f32_to_real(b_mat[k*8+j]);
                     prod = f32_to_real(real_to_f32(prod));
                     acc = f32_to_real(real_to_f32(acc + prod));
                  end
                  e.row = 3'(i);
                  e.col = 3'(j);
                  e.sum = real_to_f32(acc);
                  e.last = (i == nr - 1 && j == nc - 1);
                  c_expect_q.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Driver: present queued commands, random gaps between transfers outside fast mode
   int gap_left = 0;
   always @(posedge clock) begin
      mm_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            apply_cmd('{opcode_type'(req_opcode), req_row_index, req_col_index,
                        req_element_bits});
         if (req_valid && !req_ready) begin
            // hold until transfer
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            nxt = cmd_q.pop_front();
            req_opcode <= nxt.op;
            req_row_index <= nxt.row;
            req_col_index <= nxt.col;
            req_element_bits <= nxt.bits;
            req_valid <= 1'b1;
            gap_left <= fast_mode ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random stalls on the result side outside fast mode, compare each transfer
   int stall_left = 0;
   always @(posedge clock) begin
      c_elem_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (c_expect_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected C element row %0d col %0d sum %h last %0b",
                        $time, rsp_out_row, rsp_out_col, rsp_sum_bits, rsp_last_flag);
            end else begin
               e = c_expect_q.pop_front();
               if (rsp_out_row !== e.row) begin
                  errors++;
                  $display("%0t: out_row expected %0d actual %0d", $time, e.row, rsp_out_row);
               end
               if (rsp_out_col !== e.col) begin
                  errors++;
                  $display("%0t: out_col expected %0d actual %0d", $time, e.col, rsp_out_col);
               end
               if (rsp_sum_bits !== e.sum) begin
                  errors++;
                  $display("%0t: sum_bits expected %h actual %h", $time, e.sum, rsp_sum_bits);
               end
               if (rsp_last_flag !== e.last) begin
                  errors++;
                  $display("%0t: last_flag expected %0b actual %0b", $time, e.last,
                           rsp_last_flag);
               end
            end
         end
         if (rsp_valid && rsp_ready && !fast_mode) begin
            stall_left <= $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("FAIL float_matrix_multiply_core");
            $finish;
         end
      end
   end

   task automatic push_cmd(opcode_type op, logic [2:0] r, logic [2:0] c, logic [31:0] v);
      if (op == OP_WRITE_A) a_filled[{r, c}] = 1'b1;
      if (op == OP_WRITE_B) b_filled[{r, c}] = 1'b1;
      cmd_q.push_back('{op, r, c, v});
   endtask

   function automatic bit operands_ready();
      for (int i = 0; i < eff_dim(rows_reg); i++)
         for (int k = 0; k < eff_dim(inner_reg); k++)
            if (!a_filled[i*8+k]) return 1'b0;
      for (int k = 0; k < eff_dim(inner_reg); k++)
         for (int j = 0; j < eff_dim(cols_reg); j++)
            if (!b_filled[k*8+j]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] rand_element();
      logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                     32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                     32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                                     32'h0080_0000};
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return specials[$urandom_range(0, 9)];
         default: return {1'($urandom), 8'(119 + $urandom_range(0, 16)), 23'($urandom)};
      endcase
   endfunction

   // Wait for the block to drain, then let it settle
   task automatic drain();
      while (!(cmd_q.size() == 0 && !req_valid && c_expect_q.size() == 0))
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [3:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_A_ROWS:    rows_reg = v;
         CSR_INNER_LEN: inner_reg = v;
         CSR_B_COLS:    cols_reg = v;
         default: ;
      endcase
   endtask

   logic [3:0] cfg_rows  [7] = '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15, 4'd5, 4'd8};
   logic [3:0] cfg_inner [7] = '{4'd8, 4'd1, 4'd15, 4'd8, 4'd0, 4'd2, 4'd8};
   logic [3:0] cfg_cols  [7] = '{4'd8, 4'd1, 4'd3, 4'd1, 4'd8, 4'd7, 4'd8};

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: 2x2 operands with overflow, inf minus inf, subnormals, signed zero
      csr_write(CSR_A_ROWS, 4'd2);
      csr_write(CSR_INNER_LEN, 4'd2);
      csr_write(CSR_B_COLS, 4'd2);
      csr_write(CSR_NONE, 4'd1);
      push_cmd(OP_WRITE_A, 3'd0, 3'd0, 32'h7F7F_FFFF);
      push_cmd(OP_WRITE_A, 3'd0, 3'd1, 32'h7F7F_FFFF);
      push_cmd(OP_WRITE_A, 3'd1, 3'd0, 32'h0000_0001);
      push_cmd(OP_WRITE_A, 3'd1, 3'd1, 32'h8000_0000);
      push_cmd(OP_WRITE_B, 3'd0, 3'd0, 32'h7F7F_FFFF);
      push_cmd(OP_WRITE_B, 3'd1, 3'd0, 32'hFF80_0000);
      push_cmd(OP_WRITE_B, 3'd0, 3'd1, 32'h3F80_0000);
      push_cmd(OP_WRITE_B, 3'd1, 3'd1, 32'h0080_0000);
      push_cmd(OP_NONE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      push_cmd(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      push_cmd(OP_WRITE_A, 3'd7, 3'd7, 32'hFFFF_FFFF);
      push_cmd(OP_WRITE_B, 3'd7, 3'd7, 32'h7FC0_0001);
      push_cmd(OP_WRITE_B, 3'd1, 3'd0, 32'h3F00_0000);
      push_cmd(OP_WRITE_A, 3'd1, 3'd1, 32'h7F80_0000);
      push_cmd(OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      drain();

      // Fill both stores in full so that any later shape is readable
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++) begin
            push_cmd(OP_WRITE_A, 3'(r), 3'(c), rand_element());
            push_cmd(OP_WRITE_B, 3'(r), 3'(c), rand_element());
         end

      // Random phases over a spread of shapes, extremes included
      for (int p = 0; p < 7; p++) begin
         drain();
         fast_mode = (p % 3 == 1);
         csr_write(CSR_A_ROWS, cfg_rows[p]);
         csr_write(CSR_INNER_LEN, cfg_inner[p]);
         csr_write(CSR_B_COLS, cfg_cols[p]);
         for (int n = 0; n < 32; n++) begin
            case ($urandom_range(0, 19))
               0: push_cmd(OP_NONE, 3'($urandom), 3'($urandom), $urandom);
               1, 2: if (operands_ready())
                  push_cmd(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
               default: push_cmd($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                                 3'($urandom), 3'($urandom), rand_element());
            endcase
         end
         if (operands_ready()) push_cmd(OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      end
      drain();

      if (errors == 0)
         $display("PASS float_matrix_multiply_core");
      else
         $display("FAIL float_matrix_multiply_core");
      $finish;
   end
endmodule
